// File: rtl/i2c_master_bit_engine_unit_assert.svh
// Assertion macros for the I2C master bit engine.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_ASSERT_SVH

// Check a same-cycle or delayed consequence of a condition.
`define I2CMB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Check a consequence in the cycle after a condition.
`define I2CMB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/i2cmb_pkg.sv
// Shared types and constants for the I2C master bit engine.
// No dependencies.
package i2cmb_pkg;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd50;
  localparam int          QUEUE_DEPTH_DEF = 4;
  localparam int          PADDR_W         = 3;
  localparam logic        REG_PHASE_TICKS = 1'b0;  // word index of phase_ticks

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_CHECK = 3'd4,
    CMD_READ  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
  } out_item_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } q_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } pins_t;

endpackage

// File: rtl/i2cmb_front.sv
// Front end: accepts ticks and decodes the command code.
// Depends on i2cmb_pkg.
module i2cmb_front
  import i2cmb_pkg::*;
(
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  q_status_t q_status,
  output logic      push,
  output q_item_t   push_item
);

  cmd_t cmd;

  always_comb begin
    unique case (in_data.command)
      CMD_START: cmd = CMD_START;
      CMD_STOP:  cmd = CMD_STOP;
      CMD_WRITE: cmd = CMD_WRITE;
      CMD_CHECK: cmd = CMD_CHECK;
      CMD_READ:  cmd = CMD_READ;
      default:   cmd = CMD_NONE;  // none and unused codes
    endcase
  end

  assign in_ready             = ~q_status.full;
  assign push                 = in_valid & in_ready;
  assign push_item.cmd        = cmd;
  assign push_item.write_data = in_data.write_data;
  assign push_item.send_ack   = in_data.send_ack;
  assign push_item.sda_in     = in_data.sda_in;

endmodule

// File: rtl/i2cmb_queue.sv
// Small FIFO between the decode front end and the bit sequencer.
// Depends on i2cmb_pkg.
module i2cmb_queue
  import i2cmb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_item_t   push_item,
  input  logic      pop,
  output q_item_t   head_item,
  output q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    count_nxt = CNT_W'(count_r + CNT_W'(push) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item    = mem_r[rd_ptr_r];
  assign status.valid = (count_r != '0);
  assign status.full  = (count_r == CNT_W'(DEPTH));

endmodule

// File: rtl/i2cmb_back.sv
// Back end: I2C bit sequencer, one tick per popped item, plus result register.
// Depends on i2cmb_pkg.
module i2cmb_back
  import i2cmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] phase_ticks,
  input  q_status_t   q_status,
  input  q_item_t     q_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  cmd_t        act_r, act_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        ack_r, ack_nxt;
  logic        ack_send_r, ack_send_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic [7:0]  rbyte_r, rbyte_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic [15:0] limit;
  logic        fin;
  logic        show;
  pins_t       pins;

  function automatic pins_t show_phase(cmd_t c, logic [3:0] s, logic b, logic a);
    pins_t p;
    p = '{scl: 1'b1, sda: 1'b1};
    unique case (c)
      CMD_START: p = '{scl: (s < 4'd2), sda: (s == 4'd0)};
      CMD_STOP:  p = '{scl: (s == 4'd1), sda: 1'b0};
      CMD_WRITE: p = '{scl: (s == 4'd0), sda: b};
      CMD_CHECK: p = '{scl: (s < 4'd2), sda: 1'b1};
      CMD_READ: begin
        if (s < 4'd2) p = '{scl: (s == 4'd1), sda: 1'b1};
        else          p = '{scl: (s == 4'd3), sda: ~a};
      end
      default:   p = '{scl: 1'b1, sda: 1'b1};
    endcase
    return p;
  endfunction

  // Advance only when the result register is free or being drained.
  assign pop   = q_status.valid & (~out_valid_r | out_ready);
  assign limit = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  always_comb begin
    act_nxt      = act_r;
    step_nxt     = step_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    ack_nxt      = ack_r;
    ack_send_nxt = ack_send_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    rbyte_nxt    = rbyte_r;
    fin          = 1'b0;
    show         = 1'b0;
    pins         = '{scl: 1'b1, sda: 1'b1};
    if (pop) begin
      if (act_r == CMD_NONE) begin
        if (q_item.cmd != CMD_NONE) begin
          act_nxt  = q_item.cmd;
          step_nxt = 4'd0;
          bit_nxt  = 4'd0;
          tick_nxt = 16'd1;
          if (q_item.cmd == CMD_WRITE) shift_nxt = q_item.write_data;
          if (q_item.cmd == CMD_READ) begin
            shift_nxt    = 8'd0;
            ack_send_nxt = q_item.send_ack;
          end
          show = 1'b1;
        end
      end else if (tick_r >= limit) begin
        tick_nxt = 16'd1;
        unique case (act_r)
          CMD_START: begin
            if (step_r >= 4'd2) fin = 1'b1;
            else begin
              step_nxt = 4'(step_r + 4'd1);
              show     = 1'b1;
            end
          end
          CMD_STOP: begin
            if (step_r >= 4'd1) begin
              scl_nxt = 1'b1;
              sda_nxt = 1'b1;
              fin     = 1'b1;
            end else begin
              step_nxt = 4'(step_r + 4'd1);
              show     = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (step_r == 4'd0) begin
              step_nxt = 4'd1;
              show     = 1'b1;
            end else begin
              shift_nxt = {shift_r[6:0], 1'b0};
              bit_nxt   = 4'(bit_r + 4'd1);
              if (bit_nxt >= 4'd8) fin = 1'b1;
              else begin
                step_nxt = 4'd0;
                show     = 1'b1;
              end
            end
          end
          CMD_CHECK: begin
            if (step_r == 4'd0) ack_nxt = ~q_item.sda_in;
            if (step_r >= 4'd2) fin = 1'b1;
            else begin
              step_nxt = 4'(step_r + 4'd1);
              show     = 1'b1;
            end
          end
          CMD_READ: begin
            if (step_r == 4'd1) begin
              shift_nxt = {shift_r[6:0], q_item.sda_in};
              bit_nxt   = 4'(bit_r + 4'd1);
              if (bit_nxt >= 4'd8) begin
                rbyte_nxt = shift_nxt;
                step_nxt  = 4'd2;
              end else begin
                step_nxt = 4'd0;
              end
              show = 1'b1;
            end else if (step_r >= 4'd4) begin
              fin = 1'b1;
            end else begin
              step_nxt = 4'(step_r + 4'd1);
              show     = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          act_nxt  = CMD_NONE;
          step_nxt = 4'd0;
          bit_nxt  = 4'd0;
          tick_nxt = 16'd0;
        end
      end else begin
        tick_nxt = 16'(tick_r + 16'd1);
      end
      if (show) begin
        pins    = show_phase(act_nxt, step_nxt, shift_nxt[7], ack_send_nxt);
        scl_nxt = pins.scl;
        sda_nxt = pins.sda;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= CMD_NONE;
      step_r      <= 4'd0;
      tick_r      <= 16'd0;
      bit_r       <= 4'd0;
      shift_r     <= 8'd0;
      ack_r       <= 1'b0;
      ack_send_r  <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      rbyte_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      step_r      <= step_nxt;
      tick_r      <= tick_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      ack_r       <= ack_nxt;
      ack_send_r  <= ack_send_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      rbyte_r     <= rbyte_nxt;
      out_valid_r <= pop | (out_valid_r & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.scl_out   <= scl_nxt;
      out_data_r.sda_out   <= sda_nxt;
      out_data_r.busy_res  <= (act_nxt != CMD_NONE);
      out_data_r.done_res  <= fin;
      out_data_r.read_data <= rbyte_nxt;
      out_data_r.ack_seen  <= ack_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/i2c_master_bit_engine_unit.sv
// I2C master bit engine top level: APB register, front end, queue, sequencer.
// Depends on i2cmb_pkg, i2cmb_front, i2cmb_queue, i2cmb_back and the assert header.
//
// Usage: every input transfer is one timebase tick carrying an optional
// command (start, stop, write byte, check ack, read byte), the byte to send,
// the ACK/NACK choice for reads and the sampled SDA level. Every tick yields
// exactly one result transfer with the SCL/SDA levels to drive, busy, a
// one-tick done flag, the last read byte and the last acknowledge seen.
// Commands arriving while busy, and codes 6 and 7, are ignored.
// phase_ticks (APB register 0, reset 50) sets the ticks per bus phase; zero
// acts as one. Write it only while the engine is idle.
// Path: an input transfer is written into the queue, then the sequencer steps
// it into the result register. Throughput: one tick per cycle while the
// receiver takes results, set by the single-step sequencer update; the queue and
// the result register let the input side keep taking ticks while a result waits.
// Reset: queue and result register empty, sequencer idle, SCL and SDA
// released high, read byte and ack flag cleared, phase_ticks back to 50.
// Receiver stall: the result register holds, the sequencer halts, the queue
// fills and in_ready drops once it is full.
`include "i2c_master_bit_engine_unit_assert.svh"

module i2c_master_bit_engine_unit
  import i2cmb_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // tick input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  // APB register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] phase_ticks_r;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  q_item_t     push_item;
  q_item_t     head_item;
  q_status_t   q_status;

  // Register write completes in the access phase; pready is tied high.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_wr && paddr[PADDR_W-1] == REG_PHASE_TICKS) begin
      phase_ticks_r <= pwdata[15:0];
    end
  end

  // Read back the word addressed; unmapped words read zero.
  assign prdata = (paddr[PADDR_W-1] == REG_PHASE_TICKS) ? {16'd0, phase_ticks_r} : 32'd0;

  // Decode the command and feed the queue.
  i2cmb_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple intake from the sequencer so each side stalls on its own.
  i2cmb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  // Step the bus sequencer once per tick and register the result.
  i2cmb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks_r),
    .q_status    (q_status),
    .q_item      (head_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // A finishing tick never reports busy.
  `I2CMB_ASSERT_IMPL(a_done_not_busy, out_valid && out_data.done_res, !out_data.busy_res, "done with busy set")
  // From empty, a tick passes through the queue, then the result register.
  `I2CMB_ASSERT_IMPL(a_latency, in_valid && in_ready && !q_status.valid && !out_valid, ##2 out_valid, "result latency exceeded")
  // A register write lands in phase_ticks on the next cycle.
  `I2CMB_ASSERT_NEXT(a_cfg_write, cfg_wr && paddr[PADDR_W-1] == REG_PHASE_TICKS, phase_ticks_r == $past(pwdata[15:0]), "phase_ticks write lost")

endmodule

// File: sim/tb_i2c_master_bit_engine_unit.sv
// Self-checking testbench for the I2C master bit engine top level.
// Depends on i2cmb_pkg and the i2c_master_bit_engine_unit RTL; drives ticks, APB writes
// and result back-pressure, and predicts every result transfer tick by tick.
module tb_i2c_master_bit_engine_unit;
  import i2cmb_pkg::*;

  // Unused command codes; the engine must ignore them.
  localparam logic [2:0] CMD_RSVD_LO = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  // SDA patterns for directed commands.
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  localparam logic [PADDR_W-1:0] PHASE_TICKS_ADDR = PADDR_W'({REG_PHASE_TICKS, 2'b00});
  localparam int CYCLE_LIMIT    = 300000;
  localparam int HOLD_CYCLES    = 60;
  localparam int SEGMENT_TICKS  = 200;
  localparam int TAIL_CYCLES    = 20;
  localparam int REPORT_LIMIT   = 10;

  // Tick-accurate model of the sequencer plus the queue of results still due.
  class i2c_tick_scoreboard;
    logic [15:0] phase_len;
    logic [3:0]  seq_step;
    logic [2:0]  cur_cmd;
    logic [15:0] tick_cnt;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic        ack_flag;
    logic        ack_out;
    logic        scl_q;
    logic        sda_q;
    logic [7:0]  rx_byte;
    out_item_t   tick_results_due[$];
    int          cmd_count[8];
    int          ticks;
    int          checked;
    int          errors;

    function new();
      phase_len = PHASE_TICKS_RST;
      seq_step  = '0;
      cur_cmd   = CMD_NONE;
      tick_cnt  = '0;
      bit_cnt   = '0;
      shreg     = '0;
      ack_flag  = 1'b0;
      ack_out   = 1'b0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      rx_byte   = '0;
      ticks     = 0;
      checked   = 0;
      errors    = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
    endfunction

    function bit busy();
      return cur_cmd != CMD_NONE;
    endfunction

    // Drive the pins for the current step of the active command.
    function void show_phase();
      case (cur_cmd)
        CMD_START: begin
          scl_q = (seq_step < 2);
          sda_q = (seq_step == 0);
        end
        CMD_STOP: begin
          scl_q = (seq_step == 1);
          sda_q = 1'b0;
        end
        CMD_WRITE: begin
          scl_q = (seq_step == 0);
          sda_q = shreg[7];
        end
        CMD_CHECK: begin
          scl_q = (seq_step < 2);
          sda_q = 1'b1;
        end
        CMD_READ: begin
          if (seq_step < 2) begin
            scl_q = (seq_step == 1);
            sda_q = 1'b1;
          end else begin
            scl_q = (seq_step == 3);
            sda_q = ~ack_out;
          end
        end
        default: ;
      endcase
    endfunction

    // Close the current phase; return 1 when the command has finished.
    function bit close_phase(logic sda_smp);
      case (cur_cmd)
        CMD_START: if (seq_step >= 2) return 1'b1;
        CMD_STOP: begin
          if (seq_step >= 1) begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            return 1'b1;
          end
        end
        CMD_WRITE: begin
          if (seq_step != 0) begin
            shreg   = shreg << 1;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 8) return 1'b1;
            seq_step = '0;
            show_phase();
            return 1'b0;
          end
        end
        CMD_CHECK: begin
          if (seq_step == 0) ack_flag = ~sda_smp;
          if (seq_step >= 2) return 1'b1;
        end
        CMD_READ: begin
          if (seq_step == 1) begin
            shreg   = {shreg[6:0], sda_smp};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 8) begin
              rx_byte  = shreg;
              seq_step = 4'd2;
            end else begin
              seq_step = '0;
            end
            show_phase();
            return 1'b0;
          end
          if (seq_step >= 4) return 1'b1;
        end
        default: return 1'b1;
      endcase
      seq_step = seq_step + 4'd1;
      show_phase();
      return 1'b0;
    endfunction

    // Note an accepted tick and queue the result it must produce.
    function void predict_tick(in_item_t t);
      logic [15:0] limit;
      logic        done;
      out_item_t   r;
      limit = (phase_len == 0) ? 16'd1 : phase_len;
      done  = 1'b0;
      if (cur_cmd == CMD_NONE) begin
        if (t.command >= CMD_START && t.command <= CMD_READ) begin
          cur_cmd  = t.command;
          seq_step = '0;
          bit_cnt  = '0;
          tick_cnt = 16'd1;
          if (t.command == CMD_WRITE) shreg = t.write_data;
          if (t.command == CMD_READ) begin
            shreg   = '0;
            ack_out = t.send_ack;
          end
          cmd_count[t.command]++;
          show_phase();
        end
      end else if (tick_cnt >= limit) begin
        tick_cnt = 16'd1;
        if (close_phase(t.sda_in)) begin
          cur_cmd  = CMD_NONE;
          seq_step = '0;
          bit_cnt  = '0;
          tick_cnt = '0;
          done     = 1'b1;
        end
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
      r.scl_out   = scl_q;
      r.sda_out   = sda_q;
      r.busy_res  = busy();
      r.done_res  = done;
      r.read_data = rx_byte;
      r.ack_seen  = ack_flag;
      tick_results_due.push_back(r);
      ticks++;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("MISMATCH %s", msg);
    endfunction

    function string describe(out_item_t r);
      return $sformatf("scl=%b sda=%b busy=%b done=%b rd=%02h ack=%b", r.scl_out, r.sda_out,
                       r.busy_res, r.done_res, r.read_data, r.ack_seen);
    endfunction

    // Compare one result transfer against the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t want;
      string     bad;
      if (tick_results_due.size() == 0) begin
        flag($sformatf("unexpected result %s", describe(got)));
        return;
      end
      want = tick_results_due.pop_front();
      checked++;
      bad = "";
      if (got.scl_out   !== want.scl_out)   bad = {bad, " scl_out"};
      if (got.sda_out   !== want.sda_out)   bad = {bad, " sda_out"};
      if (got.busy_res  !== want.busy_res)  bad = {bad, " busy_res"};
      if (got.done_res  !== want.done_res)  bad = {bad, " done_res"};
      if (got.read_data !== want.read_data) bad = {bad, " read_data"};
      if (got.ack_seen  !== want.ack_seen)  bad = {bad, " ack_seen"};
      if (bad != "")
        flag($sformatf("result %0d:%s | expected %s | actual %s", checked, bad,
                       describe(want), describe(got)));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  i2c_tick_scoreboard sb = new();

  int         cycle_count = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  int         hold_requests = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  int         settings_done = 0;
  logic [2:0] bus_script[$];

  i2c_master_bit_engine_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Result side: check every transfer, then pick out_ready for the next cycle.
  // A hold request blocks the channel for a long stretch so the queue fills up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Offer one tick, idling at random first; return at the accepting edge.
  task automatic send_tick(input in_item_t t);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    sb.predict_tick(t);
  endtask

  function automatic logic pick_sda(input int sda_pat);
    if (sda_pat == SDA_RAND) return 1'($urandom_range(1));
    return (sda_pat == SDA_HIGH);
  endfunction

  // Keep ticking until the engine has finished its command.
  task automatic settle_idle(input logic [2:0] busy_cmd, input int sda_pat);
    while (sb.busy())
      send_tick(in_item_t'{busy_cmd, 8'($urandom_range(255)), 1'($urandom_range(1)),
                           pick_sda(sda_pat)});
  endtask

  task automatic run_command(input logic [2:0] cmd, input logic [7:0] wdata,
                             input logic sack, input int sda_pat,
                             input logic [2:0] busy_cmd);
    send_tick(in_item_t'{cmd, wdata, sack, pick_sda(sda_pat)});
    settle_idle(busy_cmd, sda_pat);
  endtask

  // Stop offering and wait for every predicted result to come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.tick_results_due.size() != 0) @(posedge clk);
  endtask

  // APB write of phase_ticks, then read it back.
  task automatic write_phase_ticks(input logic [15:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PHASE_TICKS_ADDR;
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.phase_len = val;
    settings_done++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[15:0] !== val)
      sb.flag($sformatf("phase_ticks readback expected %04h actual %04h", val, rd[15:0]));
  endtask

  // Queue one bus transaction: start, address byte, up to three data bytes and, mostly, a stop.
  function automatic void plan_transaction();
    int n;
    bus_script.push_back(CMD_START);
    bus_script.push_back(CMD_WRITE);
    bus_script.push_back(CMD_CHECK);
    n = $urandom_range(3);
    repeat (n) begin
      if ($urandom_range(1)) begin
        bus_script.push_back(CMD_WRITE);
        bus_script.push_back(CMD_CHECK);
      end else begin
        bus_script.push_back(CMD_READ);
      end
      // repeated start now and then
      if ($urandom_range(9) == 0) bus_script.push_back(CMD_START);
    end
    // occasionally leave the bus without a stop
    if ($urandom_range(9) != 0) bus_script.push_back(CMD_STOP);
  endfunction

  // Mostly well-formed transactions with random data and SDA; the rest is
  // idle ticks, unused codes and commands thrown at a busy engine.
  function automatic in_item_t next_tick();
    in_item_t t;
    int       roll;
    t.command    = CMD_NONE;
    t.write_data = 8'($urandom_range(255));
    t.send_ack   = 1'($urandom_range(1));
    t.sda_in     = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (sb.busy()) begin
      if (roll < 8) t.command = 3'($urandom_range(CMD_RSVD_HI, CMD_START));
    end else if (roll < 10) begin
      t.command = 3'($urandom_range(CMD_RSVD_HI, CMD_NONE));
    end else if (roll >= 25) begin
      if (bus_script.size() == 0) plan_transaction();
      t.command = bus_script.pop_front();
    end
    return t;
  endfunction

  task automatic set_idling(input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
  endtask

  task automatic run_tail_ticks();
    send_tick(in_item_t'{CMD_START, 8'h00, 1'b0, 1'b1});
    repeat (150) send_tick(next_tick());
  endtask

  initial begin
    logic [15:0] seg_phase[6];
    seg_phase = '{16'd1, 16'd2, 16'd0, 16'd4, 16'd3, 16'd1};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part; sender light idling, receiver heavy.
    set_idling(35, 69);

    // Run one start at the reset phase length, then unused codes at idle.
    run_command(CMD_START, 8'h00, 1'b0, SDA_RAND, CMD_NONE);
    send_tick(in_item_t'{CMD_RSVD_LO, 8'hFF, 1'b1, 1'b1});
    send_tick(in_item_t'{CMD_RSVD_HI, 8'h00, 1'b0, 1'b0});
    drain_results();
    write_phase_ticks(16'd1);

    // Walk every command at the extremes of its fields.
    run_command(CMD_WRITE, 8'h00, 1'b0, SDA_HIGH, CMD_NONE);
    run_command(CMD_WRITE, 8'hFF, 1'b1, SDA_LOW, CMD_NONE);
    // commands arriving while busy must be dropped
    run_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND, CMD_READ);
    run_command(CMD_CHECK, 8'h00, 1'b0, SDA_LOW, CMD_NONE);
    run_command(CMD_CHECK, 8'hFF, 1'b1, SDA_HIGH, CMD_START);
    run_command(CMD_READ, 8'hFF, 1'b1, SDA_HIGH, CMD_NONE);
    run_command(CMD_READ, 8'h00, 1'b0, SDA_LOW, CMD_NONE);
    run_command(CMD_READ, 8'h5A, 1'b1, SDA_RAND, CMD_STOP);
    run_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, CMD_WRITE);
    run_command(CMD_START, 8'hFF, 1'b1, SDA_RAND, CMD_RSVD_HI);
    send_tick(in_item_t'{CMD_NONE, 8'hFF, 1'b1, 1'b0});
    send_tick(in_item_t'{CMD_RSVD_LO, 8'h00, 1'b0, 1'b1});
    drain_results();

    // Random segments, each at its own phase length, idling as scheduled.
    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) set_idling(35, 69);
      else if (seg < 4) set_idling(69, 35);
      else set_idling(0, 0);
      write_phase_ticks(seg_phase[seg]);
      for (int n = 0; n < SEGMENT_TICKS; n++) begin
        // block the result side mid segment while ticks keep coming
        if (n == SEGMENT_TICKS / 2) hold_requests++;
        // pause the sender until everything is back
        if (n == 3 * SEGMENT_TICKS / 4) drain_results();
        send_tick(next_tick());
      end
      settle_idle(CMD_NONE, SDA_RAND);
      drain_results();
    end

    // Longest phase: the command only starts; check the counter holds the pins.
    write_phase_ticks(16'hFFFF);
    run_tail_ticks();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d ticks: %0d start, %0d stop, %0d write, %0d check, %0d read",
             sb.ticks, sb.cmd_count[CMD_START], sb.cmd_count[CMD_STOP],
             sb.cmd_count[CMD_WRITE], sb.cmd_count[CMD_CHECK], sb.cmd_count[CMD_READ]);
    $display("%0d phase length settings from 0 to 65535, %0d results checked, %0d errors",
             settings_done, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.tick_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             sb.tick_results_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
